### sv/tftprx_pkg.sv
// Shared types and constants for the TFTP read-transfer receiver.
// Holds the config, result and queue-push structs and the protocol codes.
// No dependencies; every other file imports this package.
package tftprx_pkg;

    // Register file geometry
    localparam int AddrW = 4;

    // Output queue geometry
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = 2;
    localparam int FifoCntW  = 3;

    // Event codes on the request channel
    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_PACKET  = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    // Result actions
    typedef enum logic [2:0] {
        ACT_REQUEST = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_ERROR   = 3'd2,
        ACT_WRITE   = 3'd3,
        ACT_STATUS  = 3'd4
    } action_t;

    // Transfer status carried on each result
    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_DONE   = 2'd1,
        ST_FAILED = 2'd2
    } status_t;

    // Error kinds
    localparam logic ERR_UNKNOWN_ID = 1'b0;
    localparam logic ERR_ILLEGAL_OP = 1'b1;

    // Packet header constants
    localparam logic [15:0] OP_DATA      = 16'd3;
    localparam logic [15:0] OP_MAX_KNOWN = 16'd5;
    localparam logic [15:0] HDR_BYTES    = 16'd4;

    // Register indexes
    localparam logic [1:0] REG_SERVER_ADDR = 2'd0;
    localparam logic [1:0] REG_SERVER_PORT = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;
    localparam logic [1:0] REG_FULL_BYTES  = 2'd3;

    // Register reset values
    localparam logic [31:0] RST_SERVER_ADDR = 32'd0;
    localparam logic [15:0] RST_SERVER_PORT = 16'd69;
    localparam logic [3:0]  RST_RETRY_LIMIT = 4'd3;
    localparam logic [15:0] RST_FULL_BYTES  = 16'd512;

    typedef struct packed {
        logic [31:0] server_address;
        logic [15:0] server_port;
        logic [3:0]  retry_limit;
        logic [15:0] full_data_bytes;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] dest_port;
        logic [15:0] block_number;
        logic        error_kind;
        logic [15:0] payload_bytes;
        status_t     status;
        logic        last;
    } result_t;

    // Up to two results handed to the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

### sv/tftp_read_transfer_receiver_core.sv
// TFTP read-transfer receiver (client side). Each request (start, packet
// header or timeout) is held in an input register and evaluated combinationally
// against the transfer state; its zero to two results go into a four-entry
// result queue that drives the output one result per cycle while out_ready is
// high. A request is accepted every cycle while results flow; requests that
// yield two results (data block, or error plus resend/failure) are held back
// by the single-result output port. The held request is written to the queue
// once it has room for two results, and its first result is then valid from
// the queue. Configuration is through an APB-style port.
// Depends on tftprx_pkg, tftprx_cfg, tftprx_engine and tftprx_fifo.
module tftp_read_transfer_receiver_core
    import tftprx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Request channel
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       func,
    input  logic [31:0]      src_address,
    input  logic [15:0]      src_port,
    input  logic [15:0]      packet_length,
    input  logic [15:0]      packet_opcode,
    input  logic [15:0]      packet_block,
    // Result channel
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       action,
    output logic [15:0]      dest_port,
    output logic [15:0]      block_number,
    output logic             error_kind,
    output logic [15:0]      payload_bytes,
    output logic [1:0]       status,
    output logic             last
);

    cfg_t    cfg;
    push_t   push;
    logic    space_ok;
    result_t head;

    tftprx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tftprx_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .src_address   (src_address),
        .src_port      (src_port),
        .packet_length (packet_length),
        .packet_opcode (packet_opcode),
        .packet_block  (packet_block),
        .cfg           (cfg),
        .space_ok      (space_ok),
        .push          (push)
    );

    tftprx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Unpack the queue head onto the result ports
    assign action        = head.action;
    assign dest_port     = head.dest_port;
    assign block_number  = head.block_number;
    assign error_kind    = head.error_kind;
    assign payload_bytes = head.payload_bytes;
    assign status        = head.status;
    assign last          = head.last;

endmodule

### sv/tftprx_cfg.sv
// APB-style configuration registers of the TFTP read-transfer receiver.
// Depends on tftprx_pkg for the register map, reset values and cfg_t.
module tftprx_cfg
    import tftprx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.server_address  <= RST_SERVER_ADDR;
            cfg_reg.server_port     <= RST_SERVER_PORT;
            cfg_reg.retry_limit     <= RST_RETRY_LIMIT;
            cfg_reg.full_data_bytes <= RST_FULL_BYTES;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_SERVER_ADDR: cfg_reg.server_address  <= pwdata;
                REG_SERVER_PORT: cfg_reg.server_port     <= pwdata[15:0];
                REG_RETRY_LIMIT: cfg_reg.retry_limit     <= pwdata[3:0];
                REG_FULL_BYTES:  cfg_reg.full_data_bytes <= pwdata[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (paddr[3:2])
            REG_SERVER_ADDR: prdata = cfg_reg.server_address;
            REG_SERVER_PORT: prdata = {16'd0, cfg_reg.server_port};
            REG_RETRY_LIMIT: prdata = {28'd0, cfg_reg.retry_limit};
            REG_FULL_BYTES:  prdata = {16'd0, cfg_reg.full_data_bytes};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

### sv/tftprx_engine.sv
// Request register, transfer state and combinational decision logic.
// Depends on tftprx_pkg; hands zero to two results per request to the queue.
module tftprx_engine
    import tftprx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] src_address,
    input  logic [15:0] src_port,
    input  logic [15:0] packet_length,
    input  logic [15:0] packet_opcode,
    input  logic [15:0] packet_block,
    input  cfg_t        cfg,
    input  logic        space_ok,
    output push_t       push
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_REQ  = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    // Held request
    logic        item_valid_reg;
    logic [1:0]  func_reg;
    logic [31:0] src_address_reg;
    logic [15:0] src_port_reg;
    logic [15:0] packet_length_reg;
    logic [15:0] packet_opcode_reg;
    logic [15:0] packet_block_reg;

    // Transfer state
    phase_t      phase_reg, phase_next;
    logic [15:0] expected_block_reg, expected_block_next;
    logic [15:0] latched_port_reg, latched_port_next;
    logic [3:0]  retry_count_reg, retry_count_next;

    logic        fire;
    logic        take;
    logic [1:0]  res_count;
    result_t     res_first, res_second;
    logic        use_retry, failed, good;
    logic        err_valid, tail_valid;
    result_t     err_res, tail_res;
    logic [3:0]  retry_inc;
    logic [15:0] data_bytes;
    logic [15:0] port_after;
    status_t     ack_status;

    function automatic result_t mk_result(
        input action_t     a,
        input logic [15:0] port,
        input logic [15:0] blk,
        input logic        kind,
        input logic [15:0] bytes,
        input status_t     st
    );
        result_t r;
        r.action        = a;
        r.dest_port     = port;
        r.block_number  = blk;
        r.error_kind    = kind;
        r.payload_bytes = bytes;
        r.status        = st;
        r.last          = 1'b0;
        return r;
    endfunction

    // Advance the held request whenever the queue can take two results
    assign fire     = item_valid_reg && space_ok;
    assign in_ready = !item_valid_reg || fire;
    assign take     = in_valid && in_ready;

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg          <= func;
            src_address_reg   <= src_address;
            src_port_reg      <= src_port;
            packet_length_reg <= packet_length;
            packet_opcode_reg <= packet_opcode;
            packet_block_reg  <= packet_block;
        end
    end

    // Decide results and next state for the held request
    always_comb
    begin
        phase_next          = phase_reg;
        expected_block_next = expected_block_reg;
        latched_port_next   = latched_port_reg;
        retry_count_next    = retry_count_reg;
        res_count           = 2'd0;
        res_first           = mk_result(ACT_STATUS, 16'd0, 16'd0, 1'b0, 16'd0, ST_BUSY);
        res_second          = res_first;
        use_retry           = 1'b0;
        failed              = 1'b0;
        good                = 1'b0;
        err_valid           = 1'b0;
        tail_valid          = 1'b0;
        err_res             = res_first;
        tail_res            = res_first;
        retry_inc           = retry_count_reg + 4'd1;
        data_bytes          = packet_length_reg - HDR_BYTES;
        port_after          = (latched_port_reg == 16'd0) ? src_port_reg : latched_port_reg;
        ack_status          = (data_bytes < cfg.full_data_bytes) ? ST_DONE : ST_BUSY;

        if (func_reg == FUNC_START)
        begin
            // Restart: send the read request to the server
            phase_next          = PH_REQ;
            expected_block_next = 16'd1;
            latched_port_next   = 16'd0;
            retry_count_next    = 4'd0;
            res_count           = 2'd1;
            res_first           = mk_result(ACT_REQUEST, cfg.server_port, 16'd0, 1'b0,
                                            16'd0, ST_BUSY);
        end
        else if (func_reg != FUNC_NONE && phase_reg != PH_IDLE)
        begin
            // Classify the event
            if (func_reg == FUNC_TIMEOUT || packet_length_reg == 16'd0)
            begin
                use_retry = 1'b1;
            end
            else if (src_address_reg != cfg.server_address)
            begin
                use_retry = 1'b0;
            end
            else if (latched_port_reg != 16'd0 && src_port_reg != latched_port_reg)
            begin
                err_valid = 1'b1;
                err_res   = mk_result(ACT_ERROR, src_port_reg, 16'd0, ERR_UNKNOWN_ID,
                                      16'd0, ST_BUSY);
            end
            else if (packet_length_reg < HDR_BYTES)
            begin
                use_retry = 1'b1;
            end
            else if (packet_opcode_reg != OP_DATA || packet_block_reg != expected_block_reg)
            begin
                err_valid = packet_opcode_reg > OP_MAX_KNOWN;
                err_res   = mk_result(ACT_ERROR, src_port_reg, 16'd0, ERR_ILLEGAL_OP,
                                      16'd0, ST_BUSY);
                use_retry = 1'b1;
            end
            else
            begin
                good = 1'b1;
            end

            if (good)
            begin
                // Accept the block: write payload, then ack it
                latched_port_next   = port_after;
                phase_next          = (ack_status == ST_DONE) ? PH_IDLE : PH_RECV;
                expected_block_next = expected_block_reg + 16'd1;
                retry_count_next    = 4'd0;
                res_count           = 2'd2;
                res_first           = mk_result(ACT_WRITE, 16'd0, 16'd0, 1'b0, data_bytes,
                                                ST_BUSY);
                res_second          = mk_result(ACT_ACK, port_after, expected_block_reg, 1'b0,
                                                16'd0, ack_status);
            end
            else
            begin
                // Use a retry and fail at the limit
                if (use_retry)
                begin
                    retry_count_next = retry_inc;
                    failed           = retry_inc >= cfg.retry_limit;
                end
                if (failed)
                begin
                    phase_next = PH_IDLE;
                    tail_valid = 1'b1;
                    tail_res   = mk_result(ACT_STATUS, 16'd0, 16'd0, 1'b0, 16'd0, ST_FAILED);
                end
                else if (phase_reg == PH_REQ)
                begin
                    latched_port_next = 16'd0;
                    tail_valid        = 1'b1;
                    tail_res          = mk_result(ACT_REQUEST, cfg.server_port, 16'd0, 1'b0,
                                                  16'd0, ST_BUSY);
                end

                // Order: error first, then request resend or failure status
                if (err_valid)
                begin
                    res_first = err_res;
                    if (tail_valid)
                    begin
                        res_second = tail_res;
                        res_count  = 2'd2;
                    end
                    else
                    begin
                        res_count = 2'd1;
                    end
                end
                else if (tail_valid)
                begin
                    res_first = tail_res;
                    res_count = 2'd1;
                end
            end
        end

        // Mark the final result of the request
        if (res_count == 2'd1)
        begin
            res_first.last = 1'b1;
        end
        else if (res_count == 2'd2)
        begin
            res_second.last = 1'b1;
        end
    end

    assign push.count  = fire ? res_count : 2'd0;
    assign push.first  = res_first;
    assign push.second = res_second;

    // Hold request valid and transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            phase_reg          <= PH_IDLE;
            expected_block_reg <= 16'd0;
            latched_port_reg   <= 16'd0;
            retry_count_reg    <= 4'd0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                phase_reg          <= phase_next;
                expected_block_reg <= expected_block_next;
                latched_port_reg   <= latched_port_next;
                retry_count_reg    <= retry_count_next;
            end
        end
    end

endmodule

### sv/tftprx_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on tftprx_pkg for result_t, push_t and the queue geometry.
module tftprx_fifo
    import tftprx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t               mem_reg [FifoDepth];
    logic [FifoPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FifoPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FifoCntW-1:0]   count_reg, count_next;
    logic [FifoPtrW-1:0]   wr_ptr_second;
    logic                  pop;

    assign space_ok      = count_reg <= FifoCntW'(FifoDepth - 2);
    assign out_valid     = count_reg != '0;
    assign head          = mem_reg[rd_ptr_reg];
    assign pop           = out_valid && out_ready;
    assign wr_ptr_second = wr_ptr_reg + FifoPtrW'(1);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FifoPtrW'(push.count);
        rd_ptr_next = rd_ptr_reg + FifoPtrW'(pop);
        count_next  = count_reg + FifoCntW'(push.count) - FifoCntW'(pop);
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### tb/tb.sv
// Testbench for the TFTP read-transfer receiver core: a directed table, random transfers under several
// register settings and a closing block stream, all checked against a cycle-free client model.
// Depends on tftprx_pkg and tftp_read_transfer_receiver_core.
module tb;
    import tftprx_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_REQUESTED = 2'd1,
        PH_RECEIVING = 2'd2
    } xfer_phase_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_COMPUTED   = 2'd0,
        ROW_SILENT     = 2'd1,
        ROW_ONE_ACTION = 2'd2
    } row_check_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] len;
        logic [15:0] opcode;
        logic [15:0] blk;
    } request_t;

    typedef struct packed {
        request_t   rq;
        row_check_t check;
        result_t    want;
    } directed_row_t;

    localparam result_t NO_ACTION = '0;
    localparam result_t RESEND =
        '{ACT_REQUEST, RST_SERVER_PORT, 16'd0, ERR_UNKNOWN_ID, 16'd0, ST_BUSY, 1'b1};
    localparam result_t GAVE_UP =
        '{ACT_STATUS, 16'd0, 16'd0, ERR_UNKNOWN_ID, 16'd0, ST_FAILED, 1'b1};
    localparam request_t START_RQ = '{FUNC_START, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       func;
    logic [31:0]      src_address;
    logic [15:0]      src_port;
    logic [15:0]      packet_length;
    logic [15:0]      packet_opcode;
    logic [15:0]      packet_block;
    logic             out_valid;
    logic             out_ready;
    logic [2:0]       action;
    logic [15:0]      dest_port;
    logic [15:0]      block_number;
    logic             error_kind;
    logic [15:0]      payload_bytes;
    logic [1:0]       status;
    logic             last;

    // Client state and register copies
    logic [31:0] cfg_server_address = RST_SERVER_ADDR;
    logic [15:0] cfg_server_port    = RST_SERVER_PORT;
    logic [3:0]  cfg_retry_limit    = RST_RETRY_LIMIT;
    logic [15:0] cfg_full_bytes     = RST_FULL_BYTES;
    xfer_phase_t xfer_phase         = PH_IDLE;
    logic [15:0] xfer_block         = 16'd0;
    logic [15:0] xfer_latched       = 16'd0;
    logic [3:0]  xfer_retries       = 4'd0;

    result_t due_actions [$];
    int      failures          = 0;
    bit      sender_steady     = 1'b0;
    bit      receiver_steady   = 1'b0;
    bit      long_hold_pending = 1'b0;

    directed_row_t directed_rows [24] = '{
        // events while idle are dropped
        '{'{FUNC_TIMEOUT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0}, ROW_SILENT, NO_ACTION},
        '{'{FUNC_PACKET, 32'd0, 16'd100, 16'd516, OP_DATA, 16'd1}, ROW_SILENT, NO_ACTION},
        '{'{FUNC_NONE, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0}, ROW_SILENT, NO_ACTION},
        '{START_RQ, ROW_ONE_ACTION, RESEND},
        // first block awaited: rejections resend the read request until the retry limit fails the transfer
        '{'{FUNC_PACKET, 32'hFFFF_FFFF, 16'd100, 16'd516, OP_DATA, 16'd1},
            ROW_ONE_ACTION, RESEND},
        '{'{FUNC_PACKET, 32'd0, 16'd100, 16'd0, OP_DATA, 16'd1}, ROW_ONE_ACTION, RESEND},
        '{'{FUNC_PACKET, 32'd0, 16'd100, 16'd3, OP_DATA, 16'd1}, ROW_ONE_ACTION, RESEND},
        '{'{FUNC_PACKET, 32'd0, 16'd100, 16'd516, 16'hFFFF, 16'd1}, ROW_COMPUTED, NO_ACTION},
        '{START_RQ, ROW_ONE_ACTION, RESEND},
        // port zero stays unlatched, then the next port latches
        '{'{FUNC_PACKET, 32'd0, 16'd0, 16'd516, OP_DATA, 16'd1}, ROW_COMPUTED, NO_ACTION},
        '{'{FUNC_PACKET, 32'd0, 16'hFFFF, 16'd516, OP_DATA, 16'd2}, ROW_COMPUTED, NO_ACTION},
        '{'{FUNC_PACKET, 32'd0, 16'd1234, 16'd516, OP_DATA, 16'd3}, ROW_ONE_ACTION,
            '{ACT_ERROR, 16'd1234, 16'd0, ERR_UNKNOWN_ID, 16'd0, ST_BUSY, 1'b1}},
        '{'{FUNC_PACKET, 32'd0, 16'hFFFF, 16'd516, 16'd0, 16'd3}, ROW_SILENT, NO_ACTION},
        '{'{FUNC_PACKET, 32'd0, 16'hFFFF, 16'd516, OP_DATA, 16'hFFFF}, ROW_SILENT, NO_ACTION},
        '{'{FUNC_TIMEOUT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0}, ROW_ONE_ACTION, GAVE_UP},
        // empty block finishes at once
        '{START_RQ, ROW_ONE_ACTION, RESEND},
        '{'{FUNC_PACKET, 32'd0, 16'd5000, 16'd4, OP_DATA, 16'd1}, ROW_COMPUTED, NO_ACTION},
        '{START_RQ, ROW_ONE_ACTION, RESEND},
        '{'{FUNC_PACKET, 32'd0, 16'd5000, 16'hFFFF, OP_DATA, 16'd1}, ROW_COMPUTED, NO_ACTION},
        '{'{FUNC_PACKET, 32'hFFFF_FFFF, 16'd5000, 16'd516, OP_DATA, 16'd2},
            ROW_SILENT, NO_ACTION},
        '{'{FUNC_PACKET, 32'd0, 16'd5000, 16'd516, 16'd5, 16'd2}, ROW_SILENT, NO_ACTION},
        '{'{FUNC_PACKET, 32'd0, 16'd5000, 16'd516, 16'd6, 16'd2}, ROW_ONE_ACTION,
            '{ACT_ERROR, 16'd5000, 16'd0, ERR_ILLEGAL_OP, 16'd0, ST_BUSY, 1'b1}},
        // restart while busy, then a short block
        '{START_RQ, ROW_ONE_ACTION, RESEND},
        '{'{FUNC_PACKET, 32'd0, 16'd5000, 16'd515, OP_DATA, 16'd1}, ROW_COMPUTED, NO_ACTION}
    };

    tftp_read_transfer_receiver_core u_top (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t action_of(input action_t act, input logic [15:0] port,
                                          input logic [15:0] blk, input logic kind,
                                          input logic [15:0] bytes, input status_t st);
        return '{act, port, blk, kind, bytes, st, 1'b0};
    endfunction

    // Advance the client state by one request and return the actions it causes
    function automatic int react_to_request(input request_t rq, output result_t first,
                                            output result_t second);
        result_t     made [2];
        int          n;
        bit          spend_retry;
        bit          gave_up;
        logic [15:0] bytes;
        status_t     closing;
        n = 0;
        spend_retry = 1'b0;
        gave_up = 1'b0;
        made[0] = '0;
        made[1] = '0;
        if (rq.func == FUNC_START) begin
            xfer_phase = PH_REQUESTED;
            xfer_block = 16'd1;
            xfer_latched = 16'd0;
            xfer_retries = 4'd0;
            made[n] = action_of(ACT_REQUEST, cfg_server_port, 16'd0, ERR_UNKNOWN_ID,
                                16'd0, ST_BUSY);
            n++;
        end else if (rq.func != FUNC_NONE && xfer_phase != PH_IDLE) begin
            if (rq.func == FUNC_TIMEOUT || rq.len == 16'd0) begin
                spend_retry = 1'b1;
            end else if (rq.addr != cfg_server_address) begin
                // foreign host: drop without spending a retry
            end else if (xfer_latched != 16'd0 && rq.port != xfer_latched) begin
                made[n] = action_of(ACT_ERROR, rq.port, 16'd0, ERR_UNKNOWN_ID,
                                    16'd0, ST_BUSY);
                n++;
            end else if (rq.len < HDR_BYTES) begin
                spend_retry = 1'b1;
            end else if (rq.opcode != OP_DATA || rq.blk != xfer_block) begin
                if (rq.opcode > OP_MAX_KNOWN) begin
                    made[n] = action_of(ACT_ERROR, rq.port, 16'd0, ERR_ILLEGAL_OP,
                                        16'd0, ST_BUSY);
                    n++;
                end
                spend_retry = 1'b1;
            end else begin
                // good block: write payload, then ack it
                bytes = rq.len - HDR_BYTES;
                if (xfer_latched == 16'd0)
                    xfer_latched = rq.port;
                made[n] = action_of(ACT_WRITE, 16'd0, 16'd0, ERR_UNKNOWN_ID, bytes, ST_BUSY);
                n++;
                if (bytes < cfg_full_bytes) begin
                    closing = ST_DONE;
                    xfer_phase = PH_IDLE;
                end else begin
                    closing = ST_BUSY;
                    xfer_phase = PH_RECEIVING;
                end
                made[n] = action_of(ACT_ACK, xfer_latched, xfer_block, ERR_UNKNOWN_ID,
                                    16'd0, closing);
                n++;
                xfer_block = xfer_block + 16'd1;
                xfer_retries = 4'd0;
            end
            if (spend_retry) begin
                xfer_retries = xfer_retries + 4'd1;
                if (xfer_retries >= cfg_retry_limit) begin
                    xfer_phase = PH_IDLE;
                    gave_up = 1'b1;
                end
            end
            if (gave_up) begin
                made[n] = action_of(ACT_STATUS, 16'd0, 16'd0, ERR_UNKNOWN_ID,
                                    16'd0, ST_FAILED);
                n++;
            end else if (xfer_phase == PH_REQUESTED) begin
                xfer_latched = 16'd0;
                made[n] = action_of(ACT_REQUEST, cfg_server_port, 16'd0, ERR_UNKNOWN_ID,
                                    16'd0, ST_BUSY);
                n++;
            end
        end
        if (n > 0)
            made[n-1].last = 1'b1;
        first = made[0];
        second = made[1];
        return n;
    endfunction

    // Offer one request, hold it until accepted, then record what it should cause
    task automatic offer_request(input request_t rq, input row_check_t check,
                                 input result_t want);
        int      gap;
        int      n;
        result_t a0;
        result_t a1;
        gap = sender_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= rq.func;
        src_address   <= rq.addr;
        src_port      <= rq.port;
        packet_length <= rq.len;
        packet_opcode <= rq.opcode;
        packet_block  <= rq.blk;
        do @(posedge clk); while (!in_ready);
        n = react_to_request(rq, a0, a1);
        case (check)
            ROW_COMPUTED: begin
                if (n > 0)
                    due_actions.push_back(a0);
                if (n > 1)
                    due_actions.push_back(a1);
            end
            ROW_ONE_ACTION: due_actions.push_back(want);
            default: ;
        endcase
    endtask

    // Register write: setup cycle, access cycle, then idle before returning
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SERVER_ADDR: cfg_server_address = value;
            REG_SERVER_PORT: cfg_server_port = value[15:0];
            REG_RETRY_LIMIT: cfg_retry_limit = value[3:0];
            REG_FULL_BYTES:  cfg_full_bytes = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid, wait for outstanding actions, then let silent requests finish
    task automatic drain_actions();
        in_valid <= 1'b0;
        for (int c = 0; c < 20000 && due_actions.size() != 0; c++)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off when asked
    initial begin : result_sink
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = receiver_steady ? 0 : $urandom_range(0, 16);
            if (long_hold_pending) begin
                stall = 300;
                long_hold_pending = 1'b0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each accepted action with the oldest one due
    always @(posedge clk) begin : action_check
        result_t want;
        if (rst_n === 1'b1 && out_valid && out_ready) begin
            if (due_actions.size() == 0) begin
                $error("unexpected action %0d to port %0d", action, dest_port);
                failures++;
            end else begin
                want = due_actions.pop_front();
                if (action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    failures++;
                end
                if (dest_port !== want.dest_port) begin
                    $error("dest_port: expected %0d, got %0d", want.dest_port, dest_port);
                    failures++;
                end
                if (block_number !== want.block_number) begin
                    $error("block_number: expected %0d, got %0d", want.block_number,
                           block_number);
                    failures++;
                end
                if (error_kind !== want.error_kind) begin
                    $error("error_kind: expected %0d, got %0d", want.error_kind, error_kind);
                    failures++;
                end
                if (payload_bytes !== want.payload_bytes) begin
                    $error("payload_bytes: expected %0d, got %0d", want.payload_bytes,
                           payload_bytes);
                    failures++;
                end
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    failures++;
                end
            end
        end
    end

    initial begin : stimulus
        request_t    rq;
        int          pick;
        logic [15:0] peer_port;
        logic [31:0] new_addr;
        logic [15:0] new_port;
        logic [3:0]  new_limit;
        logic [15:0] new_full;
        peer_port = 16'd0;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= 32'd0;
        in_valid      <= 1'b0;
        func          <= FUNC_NONE;
        src_address   <= 32'd0;
        src_port      <= 16'd0;
        packet_length <= 16'd0;
        packet_opcode <= 16'd0;
        packet_block  <= 16'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under reset register values
        foreach (directed_rows[i])
            offer_request(directed_rows[i].rq, directed_rows[i].check, directed_rows[i].want);
        drain_actions();

        // Random transfers under several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    new_addr = $urandom;
                    new_port = 16'd1;
                    new_limit = 4'd1;
                    new_full = 16'd8;
                end
                1: begin
                    new_addr = '1;
                    new_port = '1;
                    new_limit = 4'd15;
                    new_full = 16'd65464;
                end
                2: begin
                    // a zero retry limit fails on the first retry
                    new_addr = '0;
                    new_port = RST_SERVER_PORT;
                    new_limit = 4'd0;
                    new_full = 16'd64;
                end
                default: begin
                    new_addr = $urandom;
                    new_port = 16'($urandom_range(1, 65535));
                    new_limit = 4'($urandom_range(1, 15));
                    new_full = 16'($urandom_range(8, (ph == 5) ? 65464 : 1024));
                end
            endcase
            write_register(REG_SERVER_ADDR, new_addr);
            write_register(REG_SERVER_PORT, 32'(new_port));
            write_register(REG_RETRY_LIMIT, 32'(new_limit));
            write_register(REG_FULL_BYTES, 32'(new_full));
            sender_steady = (ph == 1);
            receiver_steady = (ph == 2);
            long_hold_pending = (ph == 3);

            for (int i = 0; i < 280; i++) begin
                pick = $urandom_range(0, 99);
                // default: the full block the client is waiting for
                rq.func = FUNC_PACKET;
                rq.addr = cfg_server_address;
                rq.port = (xfer_latched != 16'd0) ? xfer_latched : peer_port;
                rq.len = cfg_full_bytes + HDR_BYTES + 16'($urandom_range(0, 3));
                rq.opcode = OP_DATA;
                rq.blk = xfer_block;
                if (xfer_phase == PH_IDLE && pick < 85) begin
                    rq.func = FUNC_START;
                    peer_port = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
                end else if (pick < 65) begin
                    // keep the full block
                end else if (pick < 73) begin
                    rq.len = HDR_BYTES + 16'($urandom_range(0, cfg_full_bytes - 16'd1));
                end else begin
                    case ($urandom_range(0, 9))
                        0: rq.func = FUNC_TIMEOUT;
                        1: rq.len = 16'd0;
                        2: rq.addr = cfg_server_address ^ ($urandom | 32'd1);
                        3: rq.port = 16'($urandom);
                        4: rq.len = 16'($urandom_range(1, 3));
                        5: rq.opcode = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                                            : 16'($urandom);
                        6: rq.blk = 16'($urandom);
                        7: rq.func = FUNC_NONE;
                        8: begin
                            rq.func = FUNC_START;
                            peer_port = 16'($urandom);
                        end
                        default: begin
                            rq.func = func_t'($urandom_range(0, 3));
                            rq.addr = $urandom;
                            rq.port = 16'($urandom);
                            rq.len = 16'($urandom);
                            rq.opcode = 16'($urandom);
                            rq.blk = 16'($urandom);
                        end
                    endcase
                end
                offer_request(rq, ROW_COMPUTED, NO_ACTION);
            end
            drain_actions();
        end

        // Stream full blocks back to back, then time out once and finish short
        write_register(REG_SERVER_ADDR, $urandom);
        write_register(REG_SERVER_PORT, 32'($urandom_range(1, 65535)));
        write_register(REG_RETRY_LIMIT, 32'd15);
        write_register(REG_FULL_BYTES, 32'd8);
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
        offer_request(START_RQ, ROW_COMPUTED, NO_ACTION);
        rq = '{FUNC_PACKET, cfg_server_address, 16'd4000, 16'd12, OP_DATA, 16'd0};
        for (int b = 1; b <= 40; b++) begin
            rq.blk = b[15:0];
            offer_request(rq, ROW_COMPUTED, NO_ACTION);
        end
        offer_request('{FUNC_TIMEOUT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0},
                      ROW_COMPUTED, NO_ACTION);
        rq.blk = 16'd41;
        rq.len = 16'd5;
        offer_request(rq, ROW_COMPUTED, NO_ACTION);
        drain_actions();

        if (due_actions.size() != 0) begin
            $error("%0d actions never arrived", due_actions.size());
            failures++;
        end
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop
    initial begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
sv/tftprx_pkg.sv
sv/tftprx_cfg.sv
sv/tftprx_engine.sv
sv/tftprx_fifo.sv
sv/tftp_read_transfer_receiver_core.sv
tb/tb.sv
